### hw/rtl/pts_pkg.sv
// Shared types and constants for the periodic topic scheduler.
// Used by pts_table, pts_ctrl and periodic_topic_scheduler_core.
`timescale 1ns / 1ps

package pts_pkg;

  localparam int DEF_NUM_TOPICS = 16;
  localparam int MAX_TOPICS     = 64;
  localparam int MAX_REPORTS    = 16;

  localparam int CMD_W   = 2;
  localparam int TOPIC_W = 8;
  localparam int TIME_W  = 32;
  localparam int DUE_W   = 6;
  localparam int CNT_W   = $clog2(MAX_REPORTS + 1);

  localparam int IN_DATA_W  = 80;  // 74 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 8;   // 7 bits of fields, padded to bytes

  localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK        = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN     = 2'd3;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DUE = 1'b1;

  // Table access from the controller, one cycle's worth
  typedef struct packed {
    logic              sub_we;    // store period, clear fire time, enable
    logic              unsub_we;  // disable
    logic              fire_we;   // fire time <= now
    logic [DUE_W-1:0]  wr_idx;
    logic [DUE_W-1:0]  rd_idx;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } tbl_cmd_t;

  // Registered read data, valid in the cycle after rd_idx
  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] fire;
  } tbl_rd_t;

endpackage

### hw/rtl/pts_table.sv
// Topic table: enable flops plus period and last-fire memories.
// One write and one registered read per cycle. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_table #(
  parameter int NUM_TOPICS = pts_pkg::DEF_NUM_TOPICS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::tbl_cmd_t cmd,
  output pts_pkg::tbl_rd_t  rd
);
  import pts_pkg::*;

  localparam int IDX_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;

  logic [NUM_TOPICS-1:0] en_r;
  logic [TIME_W-1:0]     period_mem [NUM_TOPICS];
  logic [TIME_W-1:0]     fire_mem   [NUM_TOPICS];
  logic [IDX_W-1:0]      wr_a;
  logic [IDX_W-1:0]      rd_a;
  tbl_rd_t               rd_r;

  assign wr_a = cmd.wr_idx[IDX_W-1:0];
  assign rd_a = cmd.rd_idx[IDX_W-1:0];
  assign rd   = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (cmd.sub_we) begin
      en_r[wr_a] <= 1'b1;
    end else if (cmd.unsub_we) begin
      en_r[wr_a] <= 1'b0;
    end
  end

  // Memories hold garbage until a subscribe; the enable bit gates that.
  always_ff @(posedge clk) begin
    if (cmd.sub_we) begin
      period_mem[wr_a] <= cmd.period;
    end
    if (cmd.sub_we) begin
      fire_mem[wr_a] <= '0;
    end else if (cmd.fire_we) begin
      fire_mem[wr_a] <= cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    rd_r.en     <= en_r[rd_a];
    rd_r.period <= period_mem[rd_a];
    rd_r.fire   <= fire_mem[rd_a];
  end

endmodule

### hw/rtl/pts_ctrl.sv
// Command decode, tick scan sequencer and output word register.
// Drives pts_table through tbl_cmd_t. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_ctrl #(
  parameter int NUM_TOPICS = pts_pkg::DEF_NUM_TOPICS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pts_pkg::CMD_W-1:0]   in_command,
  input  logic [pts_pkg::TOPIC_W-1:0] in_topic,
  input  logic [pts_pkg::TIME_W-1:0]  in_period,
  input  logic [pts_pkg::TIME_W-1:0]  in_now_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic                        out_ack_ok,
  output logic [pts_pkg::DUE_W-1:0]   out_due_topic,
  output logic                        out_last,
  output pts_pkg::tbl_cmd_t           tbl_cmd,
  input  pts_pkg::tbl_rd_t            tbl_rd
);
  import pts_pkg::*;

  localparam int IDX_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TOPICS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACK   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state_r,   state_nxt;
  logic              iss_r,     iss_nxt;
  logic [IDX_W-1:0]  idx_r,     idx_nxt;
  logic              ev_r,      ev_nxt;
  logic [IDX_W-1:0]  ev_idx_r,  ev_idx_nxt;
  logic [TIME_W-1:0] now_r,     now_nxt;
  logic              ack_ok_r,  ack_ok_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic              pend_r,    pend_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;

  logic              oval_r,  oval_nxt;
  logic              okind_r, okind_nxt;
  logic              ook_r,   ook_nxt;
  logic [DUE_W-1:0]  otop_r,  otop_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic              in_take;
  logic              in_range;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              hit;
  logic              stall;

  assign out_free = !oval_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign in_range = in_topic < TOPIC_W'(NUM_TOPICS);

  // wrapping elapsed time, compared signed against the period
  assign elapsed = now_r - tbl_rd.fire;
  assign due     = $signed(elapsed) > $signed(tbl_rd.period);
  assign hit     = (state_r == ST_SCAN) && ev_r && tbl_rd.en && due &&
                   (cnt_r < CNT_W'(MAX_REPORTS));
  // a second hit needs the held report moved out first
  assign stall   = hit && pend_r && !out_free;

  assign out_valid     = oval_r;
  assign out_kind      = okind_r;
  assign out_ack_ok    = ook_r;
  assign out_due_topic = otop_r;
  assign out_last      = olast_r;

  always_comb begin
    state_nxt    = state_r;
    iss_nxt      = iss_r;
    idx_nxt      = idx_r;
    ev_nxt       = 1'b0;
    ev_idx_nxt   = ev_idx_r;
    now_nxt      = now_r;
    ack_ok_nxt   = ack_ok_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;

    oval_nxt  = oval_r && !out_ready;
    okind_nxt = okind_r;
    ook_nxt   = ook_r;
    otop_nxt  = otop_r;
    olast_nxt = olast_r;

    tbl_cmd          = '0;
    tbl_cmd.rd_idx   = DUE_W'(idx_r);
    tbl_cmd.wr_idx   = in_topic[DUE_W-1:0];
    tbl_cmd.period   = in_period;
    tbl_cmd.now      = now_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_command)
            CMD_SUBSCRIBE: begin
              tbl_cmd.sub_we = in_range;
              ack_ok_nxt     = in_range;
              state_nxt      = ST_ACK;
            end
            CMD_UNSUBSCRIBE: begin
              tbl_cmd.unsub_we = in_range;
              ack_ok_nxt       = in_range;
              state_nxt        = ST_ACK;
            end
            CMD_TICK: begin
              now_nxt   = in_now_ms;
              iss_nxt   = 1'b1;
              idx_nxt   = '0;
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: begin
              ack_ok_nxt = 1'b0;
              state_nxt  = ST_ACK;
            end
          endcase
        end
      end

      ST_ACK: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          okind_nxt = KIND_ACK;
          ook_nxt   = ack_ok_r;
          otop_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (stall) begin
          // re-read the stalled entry so its data is there next cycle
          tbl_cmd.rd_idx = DUE_W'(ev_idx_r);
          ev_nxt         = 1'b1;
        end else begin
          if (iss_r) begin
            ev_nxt     = 1'b1;
            ev_idx_nxt = idx_r;
            idx_nxt    = IDX_W'(idx_r + 1'b1);
            iss_nxt    = (idx_r != LAST_IDX);
          end
          if (hit) begin
            tbl_cmd.fire_we = 1'b1;
            tbl_cmd.wr_idx  = DUE_W'(ev_idx_r);
            cnt_nxt         = CNT_W'(cnt_r + 1'b1);
            pend_nxt        = 1'b1;
            pend_idx_nxt    = ev_idx_r;
            if (pend_r) begin
              oval_nxt  = 1'b1;
              okind_nxt = KIND_DUE;
              ook_nxt   = 1'b0;
              otop_nxt  = DUE_W'(pend_idx_r);
              olast_nxt = 1'b0;
            end
          end
          if (ev_r && ev_idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          oval_nxt  = 1'b1;
          okind_nxt = KIND_DUE;
          ook_nxt   = 1'b0;
          otop_nxt  = DUE_W'(pend_idx_r);
          olast_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= 1'b0;
      ev_r    <= 1'b0;
      pend_r  <= 1'b0;
      oval_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      ev_r    <= ev_nxt;
      pend_r  <= pend_nxt;
      oval_r  <= oval_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    now_r      <= now_nxt;
    ack_ok_r   <= ack_ok_nxt;
    pend_idx_r <= pend_idx_nxt;
    okind_r    <= okind_nxt;
    ook_r      <= ook_nxt;
    otop_r     <= otop_nxt;
    olast_r    <= olast_nxt;
  end

endmodule

### hw/rtl/periodic_topic_scheduler_core.sv
// Top level of the periodic topic scheduler: stream ports and field packing.
// Instantiates pts_ctrl and pts_table. Depends on pts_pkg.
`timescale 1ns / 1ps

// A table of NUM_TOPICS periodic topics. Subscribe, unsubscribe and unknown
// commands each give one acknowledge word (tuser 0), loaded into the output
// register from the ACK state once that register is free. A tick reads the
// table one entry per cycle, while the output side does not stall, through
// the single read port of the period and fire-time memories; every due
// topic gives one report word (tuser 1), tlast on the final one, and a
// tick with nothing due gives no word. At most 16 reports per tick; topics
// beyond that stay due. Input is taken one item at a time; a finished word
// may wait in the output register while the next item is accepted.
module periodic_topic_scheduler_core #(
  parameter int NUM_TOPICS = pts_pkg::DEF_NUM_TOPICS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // command[1:0], topic[9:2], period[41:10], now_ms[73:42], zero pad
  input  logic [pts_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // ack_ok[0], due_topic[6:1], zero pad
  output logic [pts_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[0]
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import pts_pkg::*;

  tbl_cmd_t         tbl_cmd;
  tbl_rd_t          tbl_rd;
  logic             ack_ok;
  logic [DUE_W-1:0] due_topic;

  pts_ctrl #(
    .NUM_TOPICS(NUM_TOPICS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_command   (in_tdata[1:0]),
    .in_topic     (in_tdata[9:2]),
    .in_period    (in_tdata[41:10]),
    .in_now_ms    (in_tdata[73:42]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_ack_ok   (ack_ok),
    .out_due_topic(due_topic),
    .out_last     (out_tlast),
    .tbl_cmd      (tbl_cmd),
    .tbl_rd       (tbl_rd)
  );

  pts_table #(
    .NUM_TOPICS(NUM_TOPICS)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (tbl_cmd),
    .rd   (tbl_rd)
  );

  assign out_tdata = {1'b0, due_topic, ack_ok};

endmodule

### tb/periodic_topic_scheduler_core_test.sv
// Self-checking bench for periodic_topic_scheduler_core: streams topic commands and
// ticks in, predicts acknowledge and due-report words and checks them in order.
// Depends on pts_pkg and the core RTL.
`timescale 1ns / 1ps

module periodic_topic_scheduler_core_test;
  import pts_pkg::*;

  localparam int N_TOPICS     = DEF_NUM_TOPICS;
  localparam int TIDX_W       = $clog2(N_TOPICS);
  localparam int RANDOM_ITEMS = 185;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_GAP      = 13;

  // Packed MSB first, so a plain cast puts command in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  period;
    logic [TOPIC_W-1:0] topic;
    logic [CMD_W-1:0]   command;
  } cmd_item_t;

  typedef struct packed {
    logic             kind;
    logic             ack_ok;
    logic [DUE_W-1:0] due_topic;
    logic             last;
  } sched_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  cmd_item_t   cmd_queue[$];
  sched_word_t predicted_words[$];
  cmd_item_t   in_item;
  int          in_hold_off = 0;
  int          in_calm = 0;
  int          out_hold_off = 0;
  int          out_calm = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // shadow of the topic table
  logic              tbl_en[N_TOPICS];
  logic [TIME_W-1:0] tbl_period[N_TOPICS];
  logic [TIME_W-1:0] tbl_fire[N_TOPICS];

  periodic_topic_scheduler_core #(.NUM_TOPICS(N_TOPICS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Works out the words one accepted item causes and updates the shadow table
  task automatic schedule_step(input cmd_item_t it);
    sched_word_t       w;
    logic [TIME_W-1:0] elapsed;
    int                reports;
    reports = 0;
    w = '0;
    w.kind = KIND_ACK;
    w.last = 1'b1;
    case (it.command)
      CMD_SUBSCRIBE: begin
        w.ack_ok = (it.topic < N_TOPICS);
        if (w.ack_ok) begin
          tbl_en[it.topic[TIDX_W-1:0]] = 1'b1;
          tbl_period[it.topic[TIDX_W-1:0]] = it.period;
          tbl_fire[it.topic[TIDX_W-1:0]] = '0;
        end
        predicted_words.push_back(w);
      end
      CMD_UNSUBSCRIBE: begin
        w.ack_ok = (it.topic < N_TOPICS);
        if (w.ack_ok) tbl_en[it.topic[TIDX_W-1:0]] = 1'b0;
        predicted_words.push_back(w);
      end
      CMD_TICK: begin
        w.kind = KIND_DUE;
        w.last = 1'b0;
        for (int i = 0; i < N_TOPICS && reports < MAX_REPORTS; i++) begin
          elapsed = it.now_ms - tbl_fire[TIDX_W'(i)];
          if (tbl_en[TIDX_W'(i)] &&
              $signed(elapsed) > $signed(tbl_period[TIDX_W'(i)])) begin
            w.due_topic = DUE_W'(i);
            predicted_words.push_back(w);
            tbl_fire[TIDX_W'(i)] = it.now_ms;
            reports++;
          end
        end
        if (reports > 0) begin
          w = predicted_words.pop_back();
          w.last = 1'b1;
          predicted_words.push_back(w);
        end
      end
      default: predicted_words.push_back(w);  // unknown command, refused
    endcase
  endtask

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_word(input string what, input sched_word_t want,
                             input sched_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: want kind=%0d ok=%0d topic=%0d last=%0d, ",
                "got kind=%0d ok=%0d topic=%0d last=%0d"},
               $time, what, want.kind, want.ack_ok, want.due_topic, want.last,
               got.kind, got.ack_ok, got.due_topic, got.last);
  endtask

  // Driver: one word at a time from cmd_queue, random hold-off after each
  always @(posedge clk) begin
    logic hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      hold = in_tvalid;
      if (in_tvalid && in_tready) begin
        schedule_step(in_item);
        hold = 1'b0;
        in_hold_off = draw_gap(in_calm);
      end
      if (!hold) begin
        if (in_hold_off > 0) begin
          in_hold_off--;
        end else if (cmd_queue.size() > 0) begin
          in_item = cmd_queue.pop_front();
          in_tdata <= IN_DATA_W'(in_item);
          hold = 1'b1;
        end
      end
      in_tvalid <= hold;
    end
  end

  // Monitor: checks each accepted word against the oldest prediction
  always @(posedge clk) begin
    logic        rdy;
    sched_word_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rdy = out_tready;
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.ack_ok = out_tdata[0];
        got.due_topic = out_tdata[DUE_W:1];
        got.last = out_tlast;
        if (predicted_words.size() == 0)
          report_word("unexpected word", '0, got);
        else if (predicted_words[0] != got)
          report_word("word mismatch", predicted_words.pop_front(), got);
        else
          void'(predicted_words.pop_front());
        rdy = 1'b0;
        out_hold_off = draw_gap(out_calm);
      end
      if (!rdy) begin
        if (out_hold_off > 0) out_hold_off--;
        else rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // Watchdog: only counts while something is still owed
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cmd_queue.size() == 0 && !in_tvalid && predicted_words.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void push_cmd(input logic [CMD_W-1:0] cmd, input int unsigned topic,
                                   input logic [TIME_W-1:0] period,
                                   input logic [TIME_W-1:0] now_ms);
    cmd_item_t it;
    it.command = cmd;
    it.topic = TOPIC_W'(topic);
    it.period = period;
    it.now_ms = now_ms;
    cmd_queue.push_back(it);
  endfunction

  function automatic logic [TIME_W-1:0] random_period();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -TIME_W'($urandom_range(1, 50));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  initial begin
    logic [TIME_W-1:0] wall_ms;
    int                pick;

    for (int i = 0; i < N_TOPICS; i++) begin
      tbl_en[TIDX_W'(i)] = 1'b0;
      tbl_period[TIDX_W'(i)] = '0;
      tbl_fire[TIDX_W'(i)] = '0;
    end

    // directed: range edges, refusals, unknown command, signed compare edges
    push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, 32'd0);  // empty table, no word
    push_cmd(CMD_SUBSCRIBE, 0, 32'd0, $urandom);
    push_cmd(CMD_SUBSCRIBE, N_TOPICS, 32'd5, $urandom);
    push_cmd(CMD_SUBSCRIBE, 255, 32'h8000_0000, 32'hFFFF_FFFF);
    push_cmd(CMD_UNSUBSCRIBE, 200, $urandom, $urandom);
    push_cmd(CMD_UNKNOWN, $urandom_range(0, 255), $urandom, $urandom);
    push_cmd(CMD_SUBSCRIBE, N_TOPICS - 1, 32'h7FFF_FFFF, 32'd0);
    for (int t = 1; t < N_TOPICS - 1; t++)
      push_cmd(CMD_SUBSCRIBE, t, 32'hFFFF_FFFF, $urandom);
    push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, 32'd1);
    // elapsed equals the most negative value: nothing due
    push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, 32'h8000_0001);
    push_cmd(CMD_UNSUBSCRIBE, 0, $urandom, $urandom);
    push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, 32'hFFFF_FFFF);

    // random: mostly subscribes to live topics and ticks on a rising clock
    wall_ms = $urandom_range(0, 100);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // flood every topic with a negative period so one tick may report the full table
        for (int t = 0; t < N_TOPICS; t++)
          push_cmd(CMD_SUBSCRIBE, t, -TIME_W'($urandom_range(1, 16)), $urandom);
        push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, wall_ms);
        n += N_TOPICS;
      end else if (pick < 33) begin
        push_cmd(CMD_SUBSCRIBE,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, N_TOPICS - 1),
                 random_period(), $urandom);
      end else if (pick < 43) begin
        push_cmd(CMD_UNSUBSCRIBE,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, N_TOPICS - 1),
                 $urandom, $urandom);
      end else if (pick < 48) begin
        push_cmd(CMD_UNKNOWN, $urandom_range(0, 255), $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 19))
          0: wall_ms = $urandom;
          1: wall_ms = 32'hFFFF_FFE0 + $urandom_range(0, 15);  // about to wrap
          default: wall_ms = wall_ms + $urandom_range(0, 25);
        endcase
        push_cmd(CMD_TICK, $urandom_range(0, 255), $urandom, wall_ms);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_tvalid || predicted_words.size() != 0)
      @(posedge clk);
    // a trailing tick may still be scanning
    repeat (N_TOPICS + 20) @(posedge clk);

    if (mismatches == 0 && predicted_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
